// ----- rtl/video_frame_assembler_change_tracker_macros.svh -----
// Assertion macros used by the checker file of the frame assembler.
// Each macro samples on the rising edge of aclk and is off while aresetn is low.
`ifndef VIDEO_FRAME_ASSEMBLER_CHANGE_TRACKER_MACROS_SVH
`define VIDEO_FRAME_ASSEMBLER_CHANGE_TRACKER_MACROS_SVH

// Same-cycle implication.
`define VFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/vfa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfa_pkg
// Shared constants, codes and structs of the video frame assembler.
// ----------------------------------------------------------------------------
package vfa_pkg;

    localparam int SIG_WORDS         = 40;
    localparam int MAX_BLOCKS        = 48;
    localparam int FULL_FRAME_BLOCKS = 40;
    localparam int IDX_W             = $clog2(SIG_WORDS);
    localparam int BC_W              = 6;
    localparam int CAP_W             = 21;
    localparam int SIG_W             = 32;
    localparam int EP_W              = 16;
    localparam int CFG_DATA_W        = 21;
    localparam int S_TDATA_W         = 104;
    localparam int M_TDATA_W         = 48;

    localparam logic [CAP_W-1:0] CAPACITY_RST = 21'h100000;
    localparam logic [3:0]       BASELINE_RST = 4'd3;
    localparam logic [3:0]       STABLE_RST   = 4'd3;
    localparam logic [EP_W-1:0]  EP_CAP_RST   = 16'd600;

    typedef enum logic [1:0] {
        FUNC_BLOCK  = 2'd0,
        FUNC_TARGET = 2'd1,
        FUNC_SAFETY = 2'd2,
        FUNC_TAIL   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        COMP_FULL    = 2'd0,
        COMP_SHORT   = 2'd1,
        COMP_LONG    = 2'd2,
        COMP_ANOMALY = 2'd3
    } comp_t;

    typedef enum logic [1:0] {
        CFG_CAPACITY = 2'd0,
        CFG_BASELINE = 2'd1,
        CFG_STABLE   = 2'd2,
        CFG_EP_CAP   = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_CMP,
        ST_DECIDE,
        ST_COPY,
        ST_BLOCK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic [3:0]       baseline_needed;
        logic [3:0]       stable_needed;
        logic [EP_W-1:0]  ep_cap;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic             copy;
        logic             to_cand;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [SIG_W-1:0] wr_data;
    } eng_cmd_t;

    typedef struct packed {
        logic done;
        logic ref_eq;
        logic cand_eq;
    } eng_sts_t;

    typedef struct packed {
        logic            frame_done;
        logic [19:0]     frame_number;
        comp_t           completeness;
        logic            frame_counted;
        logic            resync_seen;
        logic            baseline_ok;
        logic            early_change;
        logic            ep_opened;
        logic            ep_ended;
        logic            ep_settled;
        logic [EP_W-1:0] episode_number;
        logic            store_full;
    } result_t;

endpackage

// ----- rtl/vfa_sig_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfa_sig_engine
// Signature stores and the word-serial compare/copy unit that sweeps them.
// ----------------------------------------------------------------------------
module vfa_sig_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  vfa_pkg::eng_cmd_t cmd,
    output vfa_pkg::eng_sts_t sts
);

    localparam logic [vfa_pkg::IDX_W-1:0] LAST_IDX =
        vfa_pkg::IDX_W'(vfa_pkg::SIG_WORDS - 1);

    logic [vfa_pkg::SIG_W-1:0] frame_mem [vfa_pkg::SIG_WORDS];
    logic [vfa_pkg::SIG_W-1:0] ref_mem   [vfa_pkg::SIG_WORDS];
    logic [vfa_pkg::SIG_W-1:0] cand_mem  [vfa_pkg::SIG_WORDS];

    logic                      run_reg;
    logic                      st2_vld_reg;
    logic                      done_reg;
    logic [vfa_pkg::IDX_W-1:0] rd_idx_reg;
    logic [vfa_pkg::IDX_W-1:0] st2_idx_reg;
    logic                      copy_reg;
    logic                      to_cand_reg;
    logic                      ref_ne_reg;
    logic                      cand_ne_reg;
    logic [vfa_pkg::SIG_W-1:0] frame_q_reg;
    logic [vfa_pkg::SIG_W-1:0] ref_q_reg;
    logic [vfa_pkg::SIG_W-1:0] cand_q_reg;

    // sweep control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= 1'b0;
            st2_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            st2_vld_reg <= run_reg;
            done_reg    <= st2_vld_reg && (st2_idx_reg == LAST_IDX);
            if (cmd.start) begin
                run_reg <= 1'b1;
            end else if (run_reg && (rd_idx_reg == LAST_IDX)) begin
                run_reg <= 1'b0;
            end
        end
    end

    // index, mode and compare result
    always_ff @(posedge aclk) begin
        st2_idx_reg <= rd_idx_reg;
        if (cmd.start) begin
            rd_idx_reg  <= '0;
            copy_reg    <= cmd.copy;
            to_cand_reg <= cmd.to_cand;
            ref_ne_reg  <= 1'b0;
            cand_ne_reg <= 1'b0;
        end else begin
            if (run_reg) begin
                rd_idx_reg <= rd_idx_reg + vfa_pkg::IDX_W'(1);
            end
            if (st2_vld_reg && !copy_reg) begin
                ref_ne_reg  <= ref_ne_reg  | (frame_q_reg != ref_q_reg);
                cand_ne_reg <= cand_ne_reg | (frame_q_reg != cand_q_reg);
            end
        end
    end

    // memories: registered reads, one write port each
    always_ff @(posedge aclk) begin
        frame_q_reg <= frame_mem[rd_idx_reg];
        ref_q_reg   <= ref_mem[rd_idx_reg];
        cand_q_reg  <= cand_mem[rd_idx_reg];
        if (cmd.wr_en) begin
            frame_mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (st2_vld_reg && copy_reg && !to_cand_reg) begin
            ref_mem[st2_idx_reg] <= frame_q_reg;
        end
        if (st2_vld_reg && copy_reg && to_cand_reg) begin
            cand_mem[st2_idx_reg] <= frame_q_reg;
        end
    end

    assign sts.done    = done_reg;
    assign sts.ref_eq  = !ref_ne_reg;
    assign sts.cand_eq = !cand_ne_reg;

endmodule

// ----- rtl/vfa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfa_ctrl
// Sequencer and scalar state: framing, classification, baseline, episodes.
// ----------------------------------------------------------------------------
module vfa_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                in_func,
    input  logic                      in_disc,
    input  logic                      in_gbi,
    input  logic [vfa_pkg::SIG_W-1:0] in_sig,
    input  vfa_pkg::cfg_t             cfg,
    input  logic                      out_free,
    output logic                      res_valid,
    output vfa_pkg::result_t          res,
    output vfa_pkg::eng_cmd_t         eng_cmd,
    input  vfa_pkg::eng_sts_t         eng_sts
);

    vfa_pkg::state_t state_reg, state_next;

    // latched item
    vfa_pkg::func_t            func_reg;
    logic                      disc_reg;
    logic                      gbi_reg;
    logic [vfa_pkg::SIG_W-1:0] sig_reg;

    logic                       anchored_reg, anchored_next;
    logic [vfa_pkg::BC_W-1:0]   bc_reg, bc_next;
    logic [vfa_pkg::BC_W-1:0]   dis_reg, dis_next;
    logic                       resync_reg, resync_next;
    logic                       bvalid_reg, bvalid_next;
    logic [3:0]                 bseen_reg, bseen_next;
    logic [vfa_pkg::CAP_W-1:0]  stored_reg, stored_next;
    logic                       full_reg, full_next;
    logic                       active_reg, active_next;
    logic [3:0]                 run_reg, run_next;
    logic [vfa_pkg::EP_W-1:0]   len_reg, len_next;
    logic [vfa_pkg::EP_W-1:0]   total_reg, total_next;
    logic                       tail_reg, tail_next;

    // result flags of the item in flight
    logic                 o_closed_reg, o_closed_next;
    logic [19:0]          o_number_reg, o_number_next;
    vfa_pkg::comp_t       o_comp_reg, o_comp_next;
    logic                 o_counted_reg, o_counted_next;
    logic                 o_resync_reg, o_resync_next;
    logic                 o_early_reg, o_early_next;
    logic                 o_opened_reg, o_opened_next;
    logic                 o_eclosed_reg, o_eclosed_next;
    logic                 o_stable_reg, o_stable_next;
    logic                 touched_reg, touched_next;

    // shared close logic
    logic                     close_go;
    logic                     cl_bnd;
    logic [vfa_pkg::BC_W-1:0] cl_bc;
    logic [vfa_pkg::BC_W-1:0] cl_dis;
    logic                     cl_has_dis;
    logic                     cl_region;
    vfa_pkg::comp_t           cl_comp;
    logic                     cl_clean;
    logic [vfa_pkg::BC_W-1:0] bc_inc;
    logic [vfa_pkg::BC_W-1:0] dis_inc;
    logic [vfa_pkg::EP_W-1:0] len_sat;
    logic [3:0]               run_sat;
    logic [3:0]               bseen_sat;
    logic                     accept;

    assign accept   = in_valid && (state_reg == vfa_pkg::ST_IDLE);
    assign in_ready = (state_reg == vfa_pkg::ST_IDLE);

    assign bc_inc    = bc_reg + vfa_pkg::BC_W'(1);
    assign dis_inc   = (disc_reg && !gbi_reg) ? dis_reg + vfa_pkg::BC_W'(1) : dis_reg;
    assign len_sat   = (len_reg == '1) ? len_reg : len_reg + vfa_pkg::EP_W'(1);
    assign run_sat   = (run_reg == 4'hF) ? run_reg : run_reg + 4'd1;
    assign bseen_sat = (bseen_reg == 4'hF) ? bseen_reg : bseen_reg + 4'd1;

    assign cl_bnd     = (state_reg == vfa_pkg::ST_PRE);
    assign cl_bc      = cl_bnd ? bc_reg : bc_inc;
    assign cl_dis     = cl_bnd ? dis_reg : dis_inc;
    assign cl_has_dis = (cl_dis != '0);

    // classify the interval being closed
    always_comb begin
        cl_region = 1'b1;
        if (cl_bnd && (cl_bc == vfa_pkg::BC_W'(vfa_pkg::FULL_FRAME_BLOCKS))) begin
            cl_comp   = vfa_pkg::COMP_FULL;
            cl_region = 1'b0;
        end else if (cl_bnd && (cl_bc < vfa_pkg::BC_W'(vfa_pkg::FULL_FRAME_BLOCKS))) begin
            cl_comp = cl_has_dis ? vfa_pkg::COMP_ANOMALY : vfa_pkg::COMP_SHORT;
        end else if (cl_bnd) begin
            cl_comp = cl_has_dis ? vfa_pkg::COMP_ANOMALY : vfa_pkg::COMP_LONG;
        end else begin
            cl_comp = vfa_pkg::COMP_LONG;
        end
        cl_clean = (cl_comp == vfa_pkg::COMP_FULL) && !cl_has_dis;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= vfa_pkg::ST_IDLE;
            anchored_reg <= 1'b0;
            bc_reg       <= '0;
            dis_reg      <= '0;
            resync_reg   <= 1'b0;
            bvalid_reg   <= 1'b0;
            bseen_reg    <= '0;
            stored_reg   <= '0;
            full_reg     <= 1'b0;
            active_reg   <= 1'b0;
            run_reg      <= '0;
            len_reg      <= '0;
            total_reg    <= '0;
            tail_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            anchored_reg <= anchored_next;
            bc_reg       <= bc_next;
            dis_reg      <= dis_next;
            resync_reg   <= resync_next;
            bvalid_reg   <= bvalid_next;
            bseen_reg    <= bseen_next;
            stored_reg   <= stored_next;
            full_reg     <= full_next;
            active_reg   <= active_next;
            run_reg      <= run_next;
            len_reg      <= len_next;
            total_reg    <= total_next;
            tail_reg     <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= vfa_pkg::func_t'(in_func);
            disc_reg <= in_disc;
            gbi_reg  <= in_gbi;
            sig_reg  <= in_sig;
        end
        o_closed_reg  <= o_closed_next;
        o_number_reg  <= o_number_next;
        o_comp_reg    <= o_comp_next;
        o_counted_reg <= o_counted_next;
        o_resync_reg  <= o_resync_next;
        o_early_reg   <= o_early_next;
        o_opened_reg  <= o_opened_next;
        o_eclosed_reg <= o_eclosed_next;
        o_stable_reg  <= o_stable_next;
        touched_reg   <= touched_next;
    end

    always_comb begin
        state_next     = state_reg;
        anchored_next  = anchored_reg;
        bc_next        = bc_reg;
        dis_next       = dis_reg;
        resync_next    = resync_reg;
        bvalid_next    = bvalid_reg;
        bseen_next     = bseen_reg;
        stored_next    = stored_reg;
        full_next      = full_reg;
        active_next    = active_reg;
        run_next       = run_reg;
        len_next       = len_reg;
        total_next     = total_reg;
        tail_next      = tail_reg;
        o_closed_next  = o_closed_reg;
        o_number_next  = o_number_reg;
        o_comp_next    = o_comp_reg;
        o_counted_next = o_counted_reg;
        o_resync_next  = o_resync_reg;
        o_early_next   = o_early_reg;
        o_opened_next  = o_opened_reg;
        o_eclosed_next = o_eclosed_reg;
        o_stable_next  = o_stable_reg;
        touched_next   = touched_reg;
        close_go       = 1'b0;
        res_valid      = 1'b0;

        eng_cmd.start   = 1'b0;
        eng_cmd.copy    = 1'b0;
        eng_cmd.to_cand = 1'b0;
        eng_cmd.wr_en   = 1'b0;
        eng_cmd.wr_addr = bc_reg[vfa_pkg::IDX_W-1:0];
        eng_cmd.wr_data = sig_reg;

        case (state_reg)
            vfa_pkg::ST_IDLE: begin
                if (accept) begin
                    o_closed_next  = 1'b0;
                    o_number_next  = '0;
                    o_comp_next    = vfa_pkg::COMP_FULL;
                    o_counted_next = 1'b0;
                    o_resync_next  = 1'b0;
                    o_early_next   = 1'b0;
                    o_opened_next  = 1'b0;
                    o_eclosed_next = 1'b0;
                    o_stable_next  = 1'b0;
                    touched_next   = 1'b0;
                    state_next     = vfa_pkg::ST_PRE;
                end
            end
            vfa_pkg::ST_PRE: begin
                state_next = vfa_pkg::ST_DONE;
                case (func_reg)
                    vfa_pkg::FUNC_BLOCK: begin
                        state_next = vfa_pkg::ST_BLOCK;
                        if (disc_reg) begin
                            if (bc_reg != '0) begin
                                if (anchored_reg) begin
                                    close_go = 1'b1;
                                end else begin
                                    bc_next  = '0;
                                    dis_next = '0;
                                end
                            end
                            anchored_next = 1'b1;
                        end
                    end
                    vfa_pkg::FUNC_TARGET: begin
                        if (active_reg) begin
                            tail_next = 1'b1;
                        end
                    end
                    vfa_pkg::FUNC_SAFETY: begin
                        if (active_reg) begin
                            active_next    = 1'b0;
                            run_next       = '0;
                            o_eclosed_next = 1'b1;
                            o_stable_next  = 1'b0;
                            touched_next   = 1'b1;
                        end
                        tail_next = 1'b0;
                    end
                    default: begin
                        tail_next = 1'b0;
                    end
                endcase
            end
            vfa_pkg::ST_CMP: begin
                if (eng_sts.done) begin
                    state_next = vfa_pkg::ST_DECIDE;
                end
            end
            vfa_pkg::ST_DECIDE: begin
                state_next = vfa_pkg::ST_BLOCK;
                if (!bvalid_reg) begin
                    // learn the baseline
                    if (bseen_reg == '0) begin
                        eng_cmd.start = 1'b1;
                        eng_cmd.copy  = 1'b1;
                        bseen_next    = 4'd1;
                        state_next    = vfa_pkg::ST_COPY;
                    end else if (eng_sts.ref_eq) begin
                        bseen_next = bseen_sat;
                        if (bseen_sat >= cfg.baseline_needed) begin
                            bvalid_next = 1'b1;
                        end
                    end else begin
                        o_early_next  = 1'b1;
                        eng_cmd.start = 1'b1;
                        eng_cmd.copy  = 1'b1;
                        bseen_next    = 4'd1;
                        state_next    = vfa_pkg::ST_COPY;
                    end
                end else if (!active_reg) begin
                    if (!eng_sts.ref_eq && !tail_reg) begin
                        total_next      = (total_reg == '1) ? total_reg
                                                            : total_reg + vfa_pkg::EP_W'(1);
                        active_next     = 1'b1;
                        len_next        = vfa_pkg::EP_W'(1);
                        run_next        = 4'd1;
                        o_opened_next   = 1'b1;
                        eng_cmd.start   = 1'b1;
                        eng_cmd.copy    = 1'b1;
                        eng_cmd.to_cand = 1'b1;
                        state_next      = vfa_pkg::ST_COPY;
                    end
                end else begin
                    len_next = len_sat;
                    if (eng_sts.cand_eq && (run_sat >= cfg.stable_needed)) begin
                        // stable: candidate equals this frame, so copy the frame
                        active_next    = 1'b0;
                        run_next       = '0;
                        o_eclosed_next = 1'b1;
                        o_stable_next  = 1'b1;
                        touched_next   = 1'b1;
                        eng_cmd.start  = 1'b1;
                        eng_cmd.copy   = 1'b1;
                        state_next     = vfa_pkg::ST_COPY;
                    end else begin
                        if (eng_sts.cand_eq) begin
                            run_next = run_sat;
                        end else begin
                            run_next        = 4'd1;
                            eng_cmd.start   = 1'b1;
                            eng_cmd.copy    = 1'b1;
                            eng_cmd.to_cand = 1'b1;
                            state_next      = vfa_pkg::ST_COPY;
                        end
                        if (len_sat >= cfg.ep_cap) begin
                            active_next    = 1'b0;
                            run_next       = '0;
                            o_eclosed_next = 1'b1;
                            o_stable_next  = 1'b0;
                            touched_next   = 1'b1;
                        end
                    end
                end
            end
            vfa_pkg::ST_COPY: begin
                if (eng_sts.done) begin
                    state_next = vfa_pkg::ST_BLOCK;
                end
            end
            vfa_pkg::ST_BLOCK: begin
                eng_cmd.wr_en = (bc_reg < vfa_pkg::BC_W'(vfa_pkg::SIG_WORDS));
                bc_next       = bc_inc;
                dis_next      = dis_inc;
                state_next    = vfa_pkg::ST_DONE;
                if (bc_inc >= vfa_pkg::BC_W'(vfa_pkg::MAX_BLOCKS)) begin
                    anchored_next = 1'b0;
                    if (anchored_reg) begin
                        close_go = 1'b1;
                    end else begin
                        bc_next  = '0;
                        dis_next = '0;
                    end
                end
            end
            vfa_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (out_free) begin
                    state_next = vfa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vfa_pkg::ST_IDLE;
            end
        endcase

        // close the interval in progress
        if (close_go) begin
            if (cl_region) begin
                resync_next   = 1'b1;
                o_resync_next = 1'b1;
            end else if (resync_reg && cl_clean) begin
                resync_next = 1'b0;
            end
            if (stored_reg >= cfg.capacity) begin
                full_next = 1'b1;
            end else begin
                o_closed_next = 1'b1;
                o_number_next = stored_reg[19:0];
                o_comp_next   = cl_comp;
                stored_next   = stored_reg + vfa_pkg::CAP_W'(1);
                if (cl_clean && !resync_reg) begin
                    o_counted_next = bvalid_reg && !full_reg;
                    eng_cmd.start  = 1'b1;
                    state_next     = vfa_pkg::ST_CMP;
                end else if (active_reg) begin
                    len_next = len_sat;
                    if (len_sat >= cfg.ep_cap) begin
                        active_next    = 1'b0;
                        run_next       = '0;
                        o_eclosed_next = 1'b1;
                        o_stable_next  = 1'b0;
                        touched_next   = 1'b1;
                    end
                end
            end
            bc_next  = '0;
            dis_next = '0;
        end
    end

    always_comb begin
        res.frame_done     = o_closed_reg;
        res.frame_number   = o_number_reg;
        res.completeness   = o_comp_reg;
        res.frame_counted  = o_counted_reg;
        res.resync_seen    = o_resync_reg;
        res.baseline_ok    = bvalid_reg;
        res.early_change   = o_early_reg;
        res.ep_opened      = o_opened_reg;
        res.ep_ended       = o_eclosed_reg;
        res.ep_settled     = o_stable_reg;
        res.episode_number = (active_reg || touched_reg) ? total_reg : '0;
        res.store_full     = full_reg;
    end

endmodule

// ----- rtl/video_frame_assembler_change_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_frame_assembler_change_tracker
// Frame assembly, classification and signature change tracking of video blocks.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per video block or command. s_tuser carries the
//   function code; s_tdata carries the boundary flags, timestamp and signature.
//   m_ channel: exactly one result word per input word, in order.
//   cfg_ port: write frame_capacity, baseline_needed, stable_needed and
//   episode_frame_cap only while the block is idle.
// Processing:
//   Commands and blocks that close no clean frame pass without a sweep.
//   Closing a clean frame outside resync runs the signature unit over all
//   40 words in a compare sweep, which a copy sweep into a store may
//   follow. The single word-wide compare/copy unit and its one read port
//   per store set the pace. One word is worked on at a time; s_tready is
//   low while it is in flight and rises as the result is loaded into the
//   output register, so the next word waits for the last one's result.
// Reset:
//   aresetn low clears framing, baseline and episode state and loads the
//   register defaults. Signature stores are not cleared.
// Stall:
//   The result is held in an output register; the next word may be accepted
//   while it waits, and the sequencer holds its own result until taken.
// ----------------------------------------------------------------------------
module video_frame_assembler_change_tracker (
    input  logic                                aclk,
    input  logic                                aresetn,
    // disc_flag[0], gbi_flag[1], timestamp[65:2], block_sig[97:66], zero pad
    input  logic [vfa_pkg::S_TDATA_W-1:0]       s_tdata,
    // func[1:0]
    input  logic [1:0]                          s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // frame_done[0], frame_number[20:1], completeness[22:21],
    // frame_counted[23], resync_seen[24], baseline_ok[25], early_change[26],
    // ep_opened[27], ep_ended[28], ep_settled[29],
    // episode_number[45:30], store_full[46], zero pad
    output logic [vfa_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [vfa_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    vfa_pkg::cfg_t     cfg_reg;
    vfa_pkg::eng_cmd_t eng_cmd;
    vfa_pkg::eng_sts_t eng_sts;
    vfa_pkg::result_t  res;
    logic              res_valid;
    logic              out_free;
    logic              m_tvalid_reg;
    logic [vfa_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.capacity        <= vfa_pkg::CAPACITY_RST;
            cfg_reg.baseline_needed <= vfa_pkg::BASELINE_RST;
            cfg_reg.stable_needed   <= vfa_pkg::STABLE_RST;
            cfg_reg.ep_cap          <= vfa_pkg::EP_CAP_RST;
        end else if (cfg_we) begin
            case (vfa_pkg::cfg_idx_t'(cfg_index))
                vfa_pkg::CFG_CAPACITY: cfg_reg.capacity        <= cfg_wdata;
                vfa_pkg::CFG_BASELINE: cfg_reg.baseline_needed <= cfg_wdata[3:0];
                vfa_pkg::CFG_STABLE:   cfg_reg.stable_needed   <= cfg_wdata[3:0];
                vfa_pkg::CFG_EP_CAP:   cfg_reg.ep_cap          <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    vfa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser),
        .in_disc   (s_tdata[0]),
        .in_gbi    (s_tdata[1]),
        .in_sig    (s_tdata[97:66]),
        .cfg       (cfg_reg),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .eng_cmd   (eng_cmd),
        .eng_sts   (eng_sts)
    );

    vfa_sig_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (eng_cmd),
        .sts     (eng_sts)
    );

    // output register: load when empty or being drained
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_valid) begin
            m_tdata_reg <= {1'b0, res.store_full, res.episode_number,
                            res.ep_settled, res.ep_ended, res.ep_opened,
                            res.early_change, res.baseline_ok, res.resync_seen,
                            res.frame_counted, res.completeness, res.frame_number,
                            res.frame_done};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/vfa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfa_checker
// Port-level checks of the frame assembler, bound to the top level.
// ----------------------------------------------------------------------------
`include "video_frame_assembler_change_tracker_macros.svh"

module vfa_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [vfa_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready
);

    logic out_stall;
    logic in_take;
    logic no_frame;
    logic stable_seen;
    logic close_ok;

    assign out_stall   = m_tvalid && !m_tready;
    assign in_take     = s_tvalid && s_tready;
    assign no_frame    = m_tvalid && !m_tdata[0];
    assign stable_seen = m_tvalid && m_tdata[29];
    assign close_ok    = m_tdata[28] && (m_tdata[45:30] != 16'd0);

    // a stalled result holds
    `VFA_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "result changed")

    // one word in flight: accept drops ready in the next cycle
    `VFA_ASSERT_NEXT(a_one_in_flight, in_take, !s_tready, "second word accepted")

    // no frame recorded means no number and no class
    `VFA_ASSERT_NOW(a_no_frame_zero, no_frame, m_tdata[22:1] == 22'd0, "frame fields set")

    // a stable close is a close
    `VFA_ASSERT_NOW(a_stable_closed, stable_seen, close_ok, "stable without close")

endmodule

bind video_frame_assembler_change_tracker vfa_checker u_vfa_checker (.*);
